### rtl/key_change_event_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// Key change event queue - assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef KEY_CHANGE_EVENT_QUEUE_UNIT_MACROS_SVH
`define KEY_CHANGE_EVENT_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, inactive during reset
`define KCEQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kceq: same-cycle check failed");

// next-cycle implication, inactive during reset
`define KCEQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kceq: next-cycle check failed");

// next-cycle implication, checked through reset as well
`define KCEQ_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("kceq: reset check failed");

`endif

### rtl/kceq_pkg.sv
// ----------------------------------------------------------------------------
// Key change event queue - package
// Sizes, packet codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package kceq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_KEYS    = 24;

    localparam int KEY_W     = 24;
    localparam int KEY_IDX_W = 5;
    localparam int CODE_W    = 8;
    localparam int EVENT_W   = KEY_IDX_W + 1;

    localparam int SCAN_KEYS = (NUM_KEYS < KEY_W) ? NUM_KEYS : KEY_W;
    localparam int SCAN_CNT_W = (SCAN_KEYS > 1) ? $clog2(SCAN_KEYS) : 1;
    localparam int PTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [SCAN_CNT_W-1:0] SCAN_LAST = SCAN_CNT_W'(SCAN_KEYS - 1);
    localparam logic [PTR_W-1:0]      PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

    localparam logic OP_PACKET  = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [CODE_W-1:0] CMD_DEBUG      = 8'd254;
    localparam logic [CODE_W-1:0] SUB_RESET_BOOT = 8'd255;
    localparam logic [CODE_W-1:0] CMD_CONFIG     = 8'd255;
    localparam logic [CODE_W-1:0] SUB_KEYS       = 8'd2;

    typedef struct packed {
        logic capture_keys;
        logic scan_en;
        logic load_event;
        logic load_reset;
    } kceq_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } kceq_status_t;

endpackage

### rtl/kceq_ctrl.sv
// ----------------------------------------------------------------------------
// Key change event queue - controller
// Decodes accepted beats and sequences key scan, queue read and response.
// ----------------------------------------------------------------------------
module kceq_ctrl
    import kceq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [CODE_W-1:0]   s_command,
    input  logic [CODE_W-1:0]   s_subcommand,
    input  kceq_status_t        status,
    output kceq_cmd_t           cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_READ = 5'b00100,
        ST_PUT  = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   is_keys;
    logic   is_boot;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign is_keys = (s_op == OP_PACKET) && (s_command == CMD_CONFIG)
                     && (s_subcommand == SUB_KEYS);
    assign is_boot = (s_op == OP_PACKET) && (s_command == CMD_DEBUG)
                     && (s_subcommand == SUB_RESET_BOOT);

    always_comb begin
        state_next       = state_reg;
        cmd.capture_keys = 1'b0;
        cmd.scan_en      = 1'b0;
        cmd.load_event   = 1'b0;
        cmd.load_reset   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == OP_DEQUEUE) begin
                        state_next = ST_READ;
                    end else if (is_boot) begin
                        state_next = ST_RESP;
                    end else if (is_keys) begin
                        cmd.capture_keys = 1'b1;
                        state_next       = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                state_next = ST_PUT;
            end
            ST_PUT: begin
                if (status.out_free) begin
                    cmd.load_event = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (status.out_free) begin
                    cmd.load_reset = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/kceq_datapath.sv
// ----------------------------------------------------------------------------
// Key change event queue - datapath
// Key store, change scan, event ring and result register.
// ----------------------------------------------------------------------------
module kceq_datapath
    import kceq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [KEY_W-1:0]     s_key_bits,
    input  kceq_cmd_t            cmd,
    output kceq_status_t         status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_event_valid,
    output logic [KEY_IDX_W-1:0] m_key_index,
    output logic                 m_key_down,
    output logic                 m_reset_request
);

    logic [EVENT_W-1:0]    ring_mem [QUEUE_DEPTH];
    logic [EVENT_W-1:0]    rd_data_reg;

    logic [SCAN_KEYS-1:0]  prev_keys_reg;
    logic [SCAN_KEYS-1:0]  diff_reg;
    logic [SCAN_KEYS-1:0]  keys_reg;
    logic [SCAN_CNT_W-1:0] scan_cnt_reg;

    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_next;
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      wr_ptr_inc;
    logic                  ring_full;
    logic                  ring_empty;
    logic                  push;

    logic                  m_valid_reg;
    logic                  ev_valid_reg;
    logic [KEY_IDX_W-1:0]  key_index_reg;
    logic                  key_down_reg;
    logic                  reset_req_reg;

    assign wr_ptr_inc  = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign ring_full   = (wr_ptr_inc == rd_ptr_reg);
    assign ring_empty  = (wr_ptr_reg == rd_ptr_reg);
    assign push        = cmd.scan_en && diff_reg[scan_cnt_reg] && !ring_full;

    assign status.scan_last = (scan_cnt_reg == SCAN_LAST);
    assign status.out_free  = !m_valid_reg || m_ready;

    // ring storage, registered read at the head
    always_ff @(posedge aclk) begin
        if (push) begin
            ring_mem[wr_ptr_reg] <= {keys_reg[scan_cnt_reg], KEY_IDX_W'(scan_cnt_reg)};
        end
        rd_data_reg <= ring_mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture_keys) begin
            diff_reg     <= prev_keys_reg ^ s_key_bits[SCAN_KEYS-1:0];
            keys_reg     <= s_key_bits[SCAN_KEYS-1:0];
            scan_cnt_reg <= '0;
        end else if (cmd.scan_en) begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_keys_reg <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
        end else begin
            if (cmd.capture_keys) begin
                prev_keys_reg <= s_key_bits[SCAN_KEYS-1:0];
            end
            if (push) begin
                wr_ptr_reg <= wr_ptr_inc;
            end
            if (cmd.load_event && !ring_empty) begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    // result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_event || cmd.load_reset) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_event) begin
            ev_valid_reg  <= !ring_empty;
            key_index_reg <= ring_empty ? '0 : rd_data_reg[KEY_IDX_W-1:0];
            key_down_reg  <= !ring_empty && rd_data_reg[KEY_IDX_W];
            reset_req_reg <= 1'b0;
        end else if (cmd.load_reset) begin
            ev_valid_reg  <= 1'b0;
            key_index_reg <= '0;
            key_down_reg  <= 1'b0;
            reset_req_reg <= 1'b1;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_valid   = ev_valid_reg;
    assign m_key_index     = key_index_reg;
    assign m_key_down      = key_down_reg;
    assign m_reset_request = reset_req_reg;

endmodule

### rtl/key_change_event_queue_unit.sv
// Dequeue: the head slot is read into a register (READ), then loaded into the result (PUT).
// Reset request: loaded into the result from RESP. Key packet: scanned one key bit per cycle.
// Other packets are accepted and dropped; one beat in work at a time.
// A waiting result holds a later dequeue or reset request until the result beat is taken.
// Reset: synchronous, active low; clears stored keys, ring pointers and result valid.
// ----------------------------------------------------------------------------
// Key change event queue unit - top level
// Turns key-state packets into per-key change events held in a ring FIFO.
// ----------------------------------------------------------------------------
module key_change_event_queue_unit
    import kceq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic [CODE_W-1:0]    s_command,
    input  logic [CODE_W-1:0]    s_subcommand,
    input  logic [KEY_W-1:0]     s_key_bits,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_event_valid,
    output logic [KEY_IDX_W-1:0] m_key_index,
    output logic                 m_key_down,
    output logic                 m_reset_request
);

    kceq_cmd_t    cmd;
    kceq_status_t status;

    kceq_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_command    (s_command),
        .s_subcommand (s_subcommand),
        .status       (status),
        .cmd          (cmd)
    );

    kceq_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_key_bits      (s_key_bits),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_valid   (m_event_valid),
        .m_key_index     (m_key_index),
        .m_key_down      (m_key_down),
        .m_reset_request (m_reset_request)
    );

endmodule

### rtl/kceq_checker.sv
// ----------------------------------------------------------------------------
// Key change event queue - port checker
// Input and result channel properties seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "key_change_event_queue_unit_macros.svh"

module kceq_checker
    import kceq_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 s_op,
    input logic [CODE_W-1:0]    s_command,
    input logic [CODE_W-1:0]    s_subcommand,
    input logic [KEY_W-1:0]     s_key_bits,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_event_valid,
    input logic [KEY_IDX_W-1:0] m_key_index,
    input logic                 m_key_down,
    input logic                 m_reset_request
);

    logic [CODE_W*2+KEY_W:0] s_beat;
    logic [KEY_IDX_W+2:0]    m_beat;

    assign s_beat = {s_op, s_command, s_subcommand, s_key_bits};
    assign m_beat = {m_event_valid, m_key_index, m_key_down, m_reset_request};

    `KCEQ_ASSERT_NEXT(a_input_held, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_beat))
    `KCEQ_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_beat))
    `KCEQ_ASSERT_NOW(a_event_or_reset, aclk, aresetn, m_valid, !(m_event_valid && m_reset_request))
    `KCEQ_ASSERT_NOW(a_no_event_clear, aclk, aresetn, m_valid && !m_event_valid, (m_key_index == '0) && !m_key_down)
    `KCEQ_ASSERT_ALWAYS_NEXT(a_reset_idle, aclk, !aresetn, !m_valid && s_ready)

endmodule

bind key_change_event_queue_unit kceq_checker u_kceq_checker (.*);

### sim/tb_key_change_event_queue_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key change event queue unit - testbench
// Drives key-state, reset-request, stray and dequeue packets. An in-bench
// tracker holds the key bits and the event ring and forecasts every result
// beat. Results are checked in order, with random gaps and stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb_key_change_event_queue_unit;
    import kceq_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 40;
    localparam int RANDOM_BEATS   = 500;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic                 hold_for_drain;
        logic                 op;
        logic [CODE_W-1:0]    command;
        logic [CODE_W-1:0]    subcommand;
        logic [KEY_W-1:0]     key_bits;
    } packet_beat_t;

    typedef struct packed {
        logic                 event_valid;
        logic [KEY_IDX_W-1:0] key_index;
        logic                 key_down;
        logic                 reset_request;
    } key_event_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_op = OP_PACKET;
    logic [CODE_W-1:0]    s_command = '0;
    logic [CODE_W-1:0]    s_subcommand = '0;
    logic [KEY_W-1:0]     s_key_bits = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_event_valid;
    logic [KEY_IDX_W-1:0] m_key_index;
    logic                 m_key_down;
    logic                 m_reset_request;

    packet_beat_t         pending_beats[$];
    key_event_t           due_events[$];
    int                   events_due = 0;
    int                   quiet_cycles = 0;
    int                   mismatches = 0;
    int                   send_gap = 0;
    int                   stall_left = 0;
    logic [15:0]          cycle_count = '0;
    logic                 calm;

    logic [KEY_W-1:0]     held_keys;
    logic [EVENT_W-1:0]   ring_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]     rd_ptr;
    logic [PTR_W-1:0]     wr_ptr;

    key_change_event_queue_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_command       (s_command),
        .s_subcommand    (s_subcommand),
        .s_key_bits      (s_key_bits),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_valid   (m_event_valid),
        .m_key_index     (m_key_index),
        .m_key_down      (m_key_down),
        .m_reset_request (m_reset_request)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    assign calm = (cycle_count[9:8] == 2'b11);

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic predict_key_events(input logic op, input logic [CODE_W-1:0] cmd,
                                      input logic [CODE_W-1:0] sub,
                                      input logic [KEY_W-1:0] keys);
        logic [KEY_W-1:0] changed;
        logic [PTR_W-1:0] nxt;
        key_event_t       ev;
        ev = '0;
        if (op == OP_DEQUEUE) begin
            if (rd_ptr != wr_ptr) begin
                ev.event_valid = 1'b1;
                ev.key_index   = ring_slot[rd_ptr][KEY_IDX_W-1:0];
                ev.key_down    = ring_slot[rd_ptr][EVENT_W-1];
                rd_ptr         = rd_ptr + PTR_W'(1);
            end
            due_events.push_back(ev);
        end else if (cmd == CMD_DEBUG && sub == SUB_RESET_BOOT) begin
            ev.reset_request = 1'b1;
            due_events.push_back(ev);
        end else if (cmd == CMD_CONFIG && sub == SUB_KEYS) begin
            changed = held_keys ^ keys;
            for (int i = 0; i < SCAN_KEYS; i++) begin
                if (changed[i]) begin
                    nxt = wr_ptr + PTR_W'(1);
                    // drop the event when the ring is full
                    if (nxt != rd_ptr) begin
                        ring_slot[wr_ptr] = {keys[i], KEY_IDX_W'(i)};
                        wr_ptr = nxt;
                    end
                end
            end
            held_keys = keys;
        end
    endtask

    task automatic queue_beat(input logic hold, input logic op, input logic [CODE_W-1:0] cmd,
                              input logic [CODE_W-1:0] sub, input logic [KEY_W-1:0] keys);
        packet_beat_t beat;
        beat.hold_for_drain = hold;
        beat.op             = op;
        beat.command        = cmd;
        beat.subcommand     = sub;
        beat.key_bits       = keys;
        pending_beats.push_back(beat);
    endtask

    always @(posedge aclk) begin : drive_beats
        logic         next_valid;
        packet_beat_t beat;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                next_valid = 1'b0;
                send_gap   = calm ? 0 : pick_gap();
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_beats.size() != 0 &&
                             (!pending_beats[0].hold_for_drain ||
                              (!s_valid && events_due == 0))) begin
                    beat = pending_beats.pop_front();
                    s_op         <= beat.op;
                    s_command    <= beat.command;
                    s_subcommand <= beat.subcommand;
                    s_key_bits   <= beat.key_bits;
                    next_valid   = 1'b1;
                end
            end
            s_valid <= next_valid;
        end
    end

    always @(posedge aclk) begin : watch_results
        key_event_t want;
        key_event_t got;
        int         gap;
        cycle_count <= cycle_count + 16'd1;
        if (!aresetn) begin
            m_ready      <= 1'b0;
            stall_left   <= 0;
            quiet_cycles <= 0;
            held_keys    = '0;
            rd_ptr       = '0;
            wr_ptr       = '0;
        end else begin
            if (s_valid && s_ready) begin
                predict_key_events(s_op, s_command, s_subcommand, s_key_bits);
            end
            if (m_valid && m_ready) begin
                got = {m_event_valid, m_key_index, m_key_down, m_reset_request};
                if (due_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: unexpected beat v=%b i=%0d d=%b r=%b",
                                 $realtime, got.event_valid, got.key_index, got.key_down,
                                 got.reset_request);
                    end
                end else begin
                    want = due_events.pop_front();
                    if (got.event_valid !== want.event_valid || got.key_index !== want.key_index ||
                        got.key_down !== want.key_down ||
                        got.reset_request !== want.reset_request) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: want v=%b i=%0d d=%b r=%b got v=%b i=%0d d=%b r=%b",
                                     $realtime, want.event_valid, want.key_index, want.key_down,
                                     want.reset_request, got.event_valid, got.key_index,
                                     got.key_down, got.reset_request);
                        end
                    end
                end
            end
            events_due <= due_events.size();
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (stall_left != 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                gap = calm ? 0 : pick_gap();
                if (gap == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready    <= 1'b0;
                    stall_left <= gap - 1;
                end
            end
        end
    end

    initial begin : run_regression
        logic [KEY_W-1:0] last_keys;
        logic [KEY_W-1:0] keys;
        int               counted;
        int               roll;
        logic             hold;
        logic             timed_out;

        // directed: empty dequeue, reset request, full ring with drops, drain past empty, stray packets
        queue_beat(1'b0, OP_DEQUEUE, 8'hFF, 8'hFF, 24'hFFFFFF);
        queue_beat(1'b0, OP_PACKET, CMD_DEBUG, SUB_RESET_BOOT, 24'h000000);
        queue_beat(1'b0, OP_PACKET, CMD_CONFIG, SUB_KEYS, 24'hFFFFFF);
        queue_beat(1'b1, OP_DEQUEUE, 8'h00, 8'h00, 24'h000000);
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            queue_beat(1'b0, OP_DEQUEUE, CODE_W'($urandom), CODE_W'($urandom),
                       KEY_W'($urandom));
        end
        queue_beat(1'b0, OP_PACKET, CMD_CONFIG, SUB_KEYS, 24'h000000);
        queue_beat(1'b0, OP_PACKET, CMD_DEBUG, 8'h00, 24'hFFFFFF);
        queue_beat(1'b0, OP_PACKET, CMD_CONFIG, 8'h03, 24'hFFFFFF);
        queue_beat(1'b0, OP_PACKET, 8'h00, 8'h00, 24'h5A5A5A);
        queue_beat(1'b0, OP_PACKET, CMD_CONFIG, SUB_KEYS, 24'h800001);
        queue_beat(1'b0, OP_DEQUEUE, 8'h00, 8'h00, 24'h000000);
        queue_beat(1'b0, OP_DEQUEUE, 8'hFF, 8'hFF, 24'hFFFFFF);

        last_keys = 24'h800001;
        counted   = 0;
        while (counted < RANDOM_BEATS) begin
            roll = $urandom_range(0, 99);
            hold = ($urandom_range(0, 59) == 0);
            if (roll < 30) begin
                case ($urandom_range(0, 2))
                    0: keys = KEY_W'($urandom);
                    1: keys = last_keys ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
                    default: keys = last_keys ^ KEY_W'($urandom & $urandom);
                endcase
                queue_beat(hold, OP_PACKET, CMD_CONFIG, SUB_KEYS, keys);
                last_keys = keys;
                counted++;
            end else if (roll < 75) begin
                queue_beat(hold, OP_DEQUEUE, CODE_W'($urandom), CODE_W'($urandom),
                           KEY_W'($urandom));
                counted++;
            end else if (roll < 85) begin
                queue_beat(hold, OP_PACKET, CMD_DEBUG, SUB_RESET_BOOT, KEY_W'($urandom));
                counted++;
            end else begin
                case ($urandom_range(0, 2))
                    0: queue_beat(1'b0, OP_PACKET, CMD_DEBUG, CODE_W'($urandom),
                                  KEY_W'($urandom));
                    1: queue_beat(1'b0, OP_PACKET, CMD_CONFIG, CODE_W'($urandom),
                                  KEY_W'($urandom));
                    default: queue_beat(1'b0, OP_PACKET, CODE_W'($urandom), CODE_W'($urandom),
                                        KEY_W'($urandom));
                endcase
                counted++;
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        while ((pending_beats.size() != 0 || s_valid || events_due != 0) &&
               quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
        end
        timed_out = (quiet_cycles >= WATCHDOG_LIMIT);
        if (timed_out) begin
            $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
        end else begin
            repeat (TAIL_CYCLES) @(posedge aclk);
            if (due_events.size() != 0) begin
                mismatches++;
                $display("%0d result beats still due at the end", due_events.size());
            end
        end
        if (!timed_out && mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### key_change_event_queue_unit.f
+incdir+rtl
rtl/kceq_pkg.sv
rtl/kceq_ctrl.sv
rtl/kceq_datapath.sv
rtl/key_change_event_queue_unit.sv
rtl/kceq_checker.sv
sim/tb_key_change_event_queue_unit.sv
